// ----- design/bsrd_pkg.sv -----
// bsrd_pkg: shared types and constants for the byte-stream radix converter.
// Used by bsrd_div and byte_stream_to_radix_digits_core; no dependencies.
package bsrd_pkg;

	localparam int RADIX_W     = 8;
	localparam int COUNT_W     = 7;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int RESULTS_MAX = 32;
	localparam int NRES_W      = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET       = 8'd62;
	localparam logic [RADIX_W-1:0] RADIX_MIN         = 8'd2;
	localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 7'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_VAL,
		ST_DIV_RNG,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/bsrd_div.sv -----
// bsrd_div: shared radix divider, restoring, one quotient bit per cycle.
// Divides a W-bit word by an 8-bit divisor; uses bsrd_pkg.
module bsrd_div #(
	parameter int W = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [W-1:0]                  dividend,
	input  logic [bsrd_pkg::RADIX_W-1:0]  divisor,
	output logic [W-1:0]                  quot,
	output logic [bsrd_pkg::RADIX_W-1:0]  rem,
	output bsrd_pkg::div_stat_t           stat
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic                           busy_q;
	logic                           done_q;
	logic [CW-1:0]                  cnt_q;
	logic [W-1:0]                   quot_q;
	logic [bsrd_pkg::RADIX_W-1:0]   rem_q;
	logic [bsrd_pkg::RADIX_W:0]     trial;
	logic [bsrd_pkg::RADIX_W:0]     diff;
	logic                           ge;

	assign trial = {rem_q, quot_q[W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[W-2:0], ge};
			rem_q  <= ge ? diff[bsrd_pkg::RADIX_W-1:0] : trial[bsrd_pkg::RADIX_W-1:0];
		end
	end

	assign quot      = quot_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/byte_stream_to_radix_digits_core.sv -----
// byte_stream_to_radix_digits_core: top level of the byte-stream radix converter.
// Uses bsrd_pkg and one shared bsrd_div instance.

// Converts a byte stream, most significant byte first, into digit_count digits of
// base radix (digit indices, least significant digit first). Each accepted byte
// with digits owed shifts into the value accumulator and scales the range by 256,
// then emits digits while value/radix < range/radix. Both quotients come from one
// shared bit-serial divider, one after the other; in_ready is low while a byte
// is being divided and its digits emitted. A byte that arrives with no digits owed
// is taken and gives no result. Radix values 0 and 1 act as 2.
module byte_stream_to_radix_digits_core #(
	parameter int ACC_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_req,
	input  logic [bsrd_pkg::BYTE_W-1:0]         data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bsrd_pkg::RADIX_W-1:0]        digit,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsrd_pkg::RADIX_W-1:0]        cfg_data
);

	localparam int W = ACC_WIDTH;

	bsrd_pkg::state_t              state_q, state_d;
	logic [bsrd_pkg::RADIX_W-1:0]  radix_q;
	logic [bsrd_pkg::COUNT_W-1:0]  count_q;
	logic [bsrd_pkg::COUNT_W-1:0]  left_q;
	logic [bsrd_pkg::NRES_W-1:0]   nres_q;
	logic [W-1:0]                  val_q;
	logic [W-1:0]                  rng_q;
	logic [W-1:0]                  qv_q;
	logic [bsrd_pkg::RADIX_W-1:0]  rv_q;
	logic [W-1:0]                  qr_q;
	logic                          out_valid_q;
	logic [bsrd_pkg::RADIX_W-1:0]  digit_q;
	logic                          last_q;

	logic [bsrd_pkg::RADIX_W-1:0]  divisor;
	logic                          div_start;
	logic [W-1:0]                  div_dividend;
	logic [W-1:0]                  div_quot;
	logic [bsrd_pkg::RADIX_W-1:0]  div_rem;
	bsrd_pkg::div_stat_t           div_stat;

	logic                          in_acc;
	logic [bsrd_pkg::COUNT_W-1:0]  left_n;
	logic [W-1:0]                  val_base;
	logic [W-1:0]                  rng_base;
	logic [W-1:0]                  val_n;
	logic [W-1:0]                  rng_n;
	logic                          slot_free;
	logic                          emit;
	logic                          more;

	assign divisor   = (radix_q < bsrd_pkg::RADIX_MIN) ? bsrd_pkg::RADIX_MIN : radix_q;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == bsrd_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign left_n   = start_req ? count_q : left_q;
	assign val_base = start_req ? '0 : val_q;
	assign rng_base = start_req ? W'(1) : rng_q;
	assign val_n    = {val_base[W-bsrd_pkg::BYTE_W-1:0], data_byte};
	assign rng_n    = {rng_base[W-bsrd_pkg::BYTE_W-1:0], {bsrd_pkg::BYTE_W{1'b0}}};

	assign emit = (state_q == bsrd_pkg::ST_EMIT) && (qv_q < qr_q) && slot_free;
	assign more = (left_q != bsrd_pkg::COUNT_W'(1))
		&& (nres_q != bsrd_pkg::NRES_W'(bsrd_pkg::RESULTS_MAX - 1));

	bsrd_div #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (divisor),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = val_n;
		unique case (state_q)
			bsrd_pkg::ST_IDLE: begin
				if (in_acc && (left_n != '0)) begin
					div_start    = 1'b1;
					div_dividend = val_n;
					state_d      = bsrd_pkg::ST_DIV_VAL;
				end
			end
			bsrd_pkg::ST_DIV_VAL: begin
				if (div_stat.done) begin
					div_start    = 1'b1;
					div_dividend = rng_q;
					state_d      = bsrd_pkg::ST_DIV_RNG;
				end
			end
			bsrd_pkg::ST_DIV_RNG: begin
				if (div_stat.done) begin
					state_d = bsrd_pkg::ST_EMIT;
				end
			end
			bsrd_pkg::ST_EMIT: begin
				if (!(qv_q < qr_q)) begin
					state_d = bsrd_pkg::ST_IDLE;
				end else if (slot_free) begin
					if (more) begin
						div_start    = 1'b1;
						div_dividend = qv_q;
						state_d      = bsrd_pkg::ST_DIV_VAL;
					end else begin
						state_d = bsrd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bsrd_pkg::ST_IDLE;
			end
		endcase
	end

	// control: config, digit counters, value and range accumulators, output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= bsrd_pkg::RADIX_RESET;
			count_q     <= bsrd_pkg::DIGIT_COUNT_RESET;
			left_q      <= '0;
			nres_q      <= '0;
			out_valid_q <= 1'b0;
			val_q       <= '0;
			rng_q       <= W'(1);
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					bsrd_pkg::CFG_RADIX:       radix_q <= cfg_data;
					bsrd_pkg::CFG_DIGIT_COUNT: count_q <= cfg_data[bsrd_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				left_q <= left_n;
				nres_q <= '0;
				if (left_n != '0) begin
					val_q <= val_n;
					rng_q <= rng_n;
				end else begin
					val_q <= val_base;
					rng_q <= rng_base;
				end
			end else if (emit) begin
				left_q <= left_q - 1'b1;
				nres_q <= nres_q + 1'b1;
				val_q  <= qv_q;
				rng_q  <= qr_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == bsrd_pkg::ST_DIV_VAL) && div_stat.done) begin
			qv_q <= div_quot;
			rv_q <= div_rem;
		end
		if ((state_q == bsrd_pkg::ST_DIV_RNG) && div_stat.done) begin
			qr_q <= div_quot;
		end
		if (emit) begin
			digit_q <= rv_q;
			last_q  <= (left_q == bsrd_pkg::COUNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;

endmodule
